### rtl/rtu_pkg.sv
// ----------------------------------------------------------------------------
// rtu_pkg: shared types for the register transfer unit
// Request/response payloads, instruction kinds and inter-stage records.
// ----------------------------------------------------------------------------
package rtu_pkg;

   // Instruction kinds; codes 14 and 15 are unused and pass through.
   typedef enum logic [3:0] {
      KIND_TAX = 4'd0,
      KIND_TAY = 4'd1,
      KIND_TXS = 4'd2,
      KIND_TCD = 4'd3,
      KIND_TCS = 4'd4,
      KIND_TDC = 4'd5,
      KIND_TSC = 4'd6,
      KIND_TSX = 4'd7,
      KIND_TXA = 4'd8,
      KIND_TYA = 4'd9,
      KIND_TXY = 4'd10,
      KIND_TYX = 4'd11,
      KIND_MVN = 4'd12,
      KIND_MVP = 4'd13
   } kind_type;

   // Destination register of a transfer.
   typedef enum logic [2:0] {
      DST_NONE,
      DST_A,
      DST_X,
      DST_Y,
      DST_S,
      DST_D
   } dest_type;

   localparam logic [15:0] WORD_ALL_ONES = 16'hFFFF;
   localparam logic [7:0]  STACK_PAGE    = 8'h01;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] acc;
      logic [15:0] index_x;
      logic [15:0] index_y;
      logic [15:0] stack_ptr;
      logic [15:0] direct_page;
      logic        mem_narrow;
      logic        index_narrow;
      logic        emulation;
      logic [15:0] bank_pair;
      logic [7:0]  read_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] acc_out;
      logic [15:0] x_out;
      logic [15:0] y_out;
      logic [15:0] s_out;
      logic [15:0] d_out;
      logic        flags_valid;
      logic        negative;
      logic        zero;
      logic        write_enable;
      logic [23:0] write_addr;
      logic [7:0]  write_data;
      logic        move_done;
   } rsp_type;

   // Transfer control decoded in the first stage.
   typedef struct packed {
      dest_type dest;
      logic     keep_high;    // replace low byte only
      logic     clear_high;   // high byte forced to 00
      logic     stack_page;   // high byte forced to 01
      logic     upd_flags;
      logic     flag_narrow;
      logic     is_move;
      logic     move_down;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [15:0] src;
      logic [15:0] acc;
      logic [15:0] index_x;
      logic [15:0] index_y;
      logic [15:0] stack_ptr;
      logic [15:0] direct_page;
      logic [7:0]  dest_bank;
      logic [7:0]  read_byte;
   } dec_type;

   typedef struct packed {
      rsp_type     regs;         // flag and done fields filled in last stage
      logic [15:0] flag_value;
      logic        flag_narrow;
   } exe_type;

endpackage

### rtl/rtu_chan_if.sv
// ----------------------------------------------------------------------------
// rtu_chan_if: valid/ready channel
// Carries one payload per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface rtu_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rtu_decode.sv
// ----------------------------------------------------------------------------
// rtu_decode: stage 1
// Decodes the kind and width bits into transfer control, picks the source.
// ----------------------------------------------------------------------------
module rtu_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rtu_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rtu_pkg::dec_type out_data
);

   logic             valid_ff;
   rtu_pkg::dec_type data_ff;
   rtu_pkg::dec_type data_in;
   rtu_pkg::ctl_type ctl;
   logic [15:0]      src;
   logic             x8;
   logic             m8;
   logic             emu;

   assign x8  = in_data.index_narrow;
   assign m8  = in_data.mem_narrow;
   assign emu = in_data.emulation;

   always_comb begin
      ctl  = '0;
      ctl.dest = rtu_pkg::DST_NONE;
      src  = in_data.acc;
      unique case (rtu_pkg::kind_type'(in_data.kind)) inside
         rtu_pkg::KIND_TAX: begin
            ctl.dest = rtu_pkg::DST_X;  ctl.keep_high = x8;
            ctl.upd_flags = 1'b1;        ctl.flag_narrow = x8;
         end
         rtu_pkg::KIND_TAY: begin
            ctl.dest = rtu_pkg::DST_Y;  ctl.keep_high = x8;
            ctl.upd_flags = 1'b1;        ctl.flag_narrow = x8;
         end
         rtu_pkg::KIND_TXS: begin
            ctl.dest = rtu_pkg::DST_S;  src = in_data.index_x;
            ctl.stack_page = emu;        ctl.clear_high = !emu && x8;
         end
         rtu_pkg::KIND_TCD: begin
            ctl.dest = rtu_pkg::DST_D;  ctl.upd_flags = 1'b1;
         end
         rtu_pkg::KIND_TCS: begin
            ctl.dest = rtu_pkg::DST_S;  ctl.stack_page = emu;
         end
         rtu_pkg::KIND_TDC: begin
            ctl.dest = rtu_pkg::DST_A;  src = in_data.direct_page;
            ctl.upd_flags = 1'b1;
         end
         rtu_pkg::KIND_TSC: begin
            ctl.dest = rtu_pkg::DST_A;  src = in_data.stack_ptr;
            ctl.upd_flags = 1'b1;
         end
         rtu_pkg::KIND_TSX: begin
            ctl.dest = rtu_pkg::DST_X;  src = in_data.stack_ptr;
            ctl.clear_high = x8;
            ctl.upd_flags = 1'b1;        ctl.flag_narrow = x8;
         end
         rtu_pkg::KIND_TXA, rtu_pkg::KIND_TYA: begin
            ctl.dest = rtu_pkg::DST_A;
            src = (rtu_pkg::kind_type'(in_data.kind) == rtu_pkg::KIND_TXA) ?
                  in_data.index_x : in_data.index_y;
            ctl.keep_high  = m8;
            ctl.clear_high = !m8 && x8;
            ctl.upd_flags = 1'b1;        ctl.flag_narrow = m8;
         end
         rtu_pkg::KIND_TXY: begin
            ctl.dest = rtu_pkg::DST_Y;  src = in_data.index_x;
            ctl.keep_high = x8;
            ctl.upd_flags = 1'b1;        ctl.flag_narrow = x8;
         end
         rtu_pkg::KIND_TYX: begin
            ctl.dest = rtu_pkg::DST_X;  src = in_data.index_y;
            ctl.keep_high = x8;
            ctl.upd_flags = 1'b1;        ctl.flag_narrow = x8;
         end
         rtu_pkg::KIND_MVN: begin
            ctl.is_move = 1'b1;
         end
         rtu_pkg::KIND_MVP: begin
            ctl.is_move = 1'b1;          ctl.move_down = 1'b1;
         end
         default: begin
            ctl.dest = rtu_pkg::DST_NONE;
         end
      endcase
   end

   always_comb begin
      data_in.ctl         = ctl;
      data_in.src         = src;
      data_in.acc         = in_data.acc;
      data_in.index_x     = in_data.index_x;
      data_in.index_y     = in_data.index_y;
      data_in.stack_ptr   = in_data.stack_ptr;
      data_in.direct_page = in_data.direct_page;
      data_in.dest_bank   = in_data.bank_pair[15:8];
      data_in.read_byte   = in_data.read_byte;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/rtu_execute.sv
// ----------------------------------------------------------------------------
// rtu_execute: stage 2
// Forms the new register file: byte merge for transfers, step for moves.
// ----------------------------------------------------------------------------
module rtu_execute (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rtu_pkg::dec_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rtu_pkg::exe_type out_data
);

   logic             valid_ff;
   rtu_pkg::exe_type data_ff;
   rtu_pkg::exe_type data_in;
   rtu_pkg::ctl_type ctl;
   logic [15:0]      old_dst;
   logic [15:0]      new_dst;
   logic [15:0]      step;

   assign ctl = in_data.ctl;

   always_comb begin
      case (ctl.dest)
         rtu_pkg::DST_A: old_dst = in_data.acc;
         rtu_pkg::DST_X: old_dst = in_data.index_x;
         rtu_pkg::DST_Y: old_dst = in_data.index_y;
         rtu_pkg::DST_S: old_dst = in_data.stack_ptr;
         rtu_pkg::DST_D: old_dst = in_data.direct_page;
         default:        old_dst = in_data.src;
      endcase
   end

   always_comb begin
      if (ctl.stack_page) begin
         new_dst = {rtu_pkg::STACK_PAGE, in_data.src[7:0]};
      end else if (ctl.keep_high) begin
         new_dst = {old_dst[15:8], in_data.src[7:0]};
      end else if (ctl.clear_high) begin
         new_dst = {8'h00, in_data.src[7:0]};
      end else begin
         new_dst = in_data.src;
      end
   end

   // +1 for MVN, -1 for MVP
   assign step = ctl.move_down ? rtu_pkg::WORD_ALL_ONES : 16'h0001;

   always_comb begin
      data_in = '0;
      data_in.regs.acc_out = (ctl.dest == rtu_pkg::DST_A) ? new_dst : in_data.acc;
      data_in.regs.x_out   = (ctl.dest == rtu_pkg::DST_X) ? new_dst : in_data.index_x;
      data_in.regs.y_out   = (ctl.dest == rtu_pkg::DST_Y) ? new_dst : in_data.index_y;
      data_in.regs.s_out   = (ctl.dest == rtu_pkg::DST_S) ? new_dst : in_data.stack_ptr;
      data_in.regs.d_out   = (ctl.dest == rtu_pkg::DST_D) ? new_dst
                                                          : in_data.direct_page;
      data_in.regs.flags_valid = ctl.upd_flags;
      data_in.flag_value  = new_dst;
      data_in.flag_narrow = ctl.flag_narrow;
      if (ctl.is_move) begin
         data_in.regs.acc_out      = in_data.acc + rtu_pkg::WORD_ALL_ONES;
         data_in.regs.x_out        = in_data.index_x + step;
         data_in.regs.y_out        = in_data.index_y + step;
         data_in.regs.write_enable = 1'b1;
         data_in.regs.write_addr   = {in_data.dest_bank, in_data.index_y};
         data_in.regs.write_data   = in_data.read_byte;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/rtu_flags.sv
// ----------------------------------------------------------------------------
// rtu_flags: stage 3
// Negative/zero from the destination at its width, move completion, output.
// ----------------------------------------------------------------------------
module rtu_flags (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rtu_pkg::exe_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rtu_pkg::rsp_type out_data
);

   logic             valid_ff;
   rtu_pkg::rsp_type data_ff;
   rtu_pkg::rsp_type data_in;
   logic             neg;
   logic             zer;

   always_comb begin
      if (in_data.flag_narrow) begin
         neg = in_data.flag_value[7];
         zer = (in_data.flag_value[7:0] == 8'h00);
      end else begin
         neg = in_data.flag_value[15];
         zer = (in_data.flag_value == 16'h0000);
      end
   end

   always_comb begin
      data_in           = in_data.regs;
      data_in.negative  = in_data.regs.flags_valid && neg;
      data_in.zero      = in_data.regs.flags_valid && zer;
      data_in.move_done = in_data.regs.write_enable &&
                          (in_data.regs.acc_out == rtu_pkg::WORD_ALL_ONES);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/cpu16_register_transfer_unit.sv
// ----------------------------------------------------------------------------
// cpu16_register_transfer_unit: 65816-style transfer and block-move step
// Three-stage pipeline: decode, execute, flags/output register.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one instruction request: kind, the current A/X/Y/S/D,
//    the width and emulation bits, and for MVN/MVP the bank pair and the
//    byte read from source bank at X.
//  - rsp_if returns one response per request, in order: the new registers,
//    N/Z with flags_valid, and for moves the write strobe, 24-bit address
//    (dest bank : Y before the step), data and move_done.
//  - A request taken by req_if passes through the decode, execute and
//    flags registers before it shows up on rsp_if; a stall can hold it
//    in any of them.
//  - Throughput is one request per cycle while rsp_if.ready stays high; a stage
//    whose request moves on takes the next one at the same edge, so no bubbles under steady flow.
//  - When rsp_if.ready is low, the output stage holds its response and the
//    stall walks back one stage per full register; req_if.ready drops only
//    once all three stages are occupied.
//  - Reset (synchronous) clears the stage valid bits; payload registers
//    are not reset. There is no architectural state beyond the pipeline.
//  - Kinds 14 and 15 pass registers through with no flags and no write.
// ----------------------------------------------------------------------------
module cpu16_register_transfer_unit (
   input  logic      clock,
   input  logic      reset,
   rtu_chan_if.sink   req_if,
   rtu_chan_if.source rsp_if
);

   logic             dec_valid;
   logic             dec_ready;
   rtu_pkg::dec_type dec_data;
   logic             exe_valid;
   logic             exe_ready;
   rtu_pkg::exe_type exe_data;
   rtu_pkg::req_type req_data;
   rtu_pkg::rsp_type rsp_data;

   assign req_data = req_if.payload;

   // Stage 1: kind decode and source select
   rtu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // Stage 2: byte merge, move step and write address
   rtu_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (exe_valid),
      .out_ready (exe_ready),
      .out_data  (exe_data)
   );

   // Stage 3: N/Z, move_done; doubles as the output register
   rtu_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exe_valid),
      .in_ready  (exe_ready),
      .in_data   (exe_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_data)
   );

   assign rsp_if.payload = rsp_data;

endmodule

### rtl/rtu_checker.sv
// ----------------------------------------------------------------------------
// rtu_checker: port-level assertions for the transfer unit
// Response hold, field consistency and pipeline latency.
// ----------------------------------------------------------------------------
module rtu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rtu_pkg::rsp_type rsp_payload
);

   // stalled response must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // non-move responses carry a clean write side
   a_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.write_enable |->
         rsp_payload.write_addr == 24'h000000 &&
         rsp_payload.write_data == 8'h00 && !rsp_payload.move_done)
      else $error("write fields set without write_enable");

   // flags only on transfers, never on moves; N/Z zero when not updated
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         !(rsp_payload.flags_valid && rsp_payload.write_enable) &&
         (rsp_payload.flags_valid || (!rsp_payload.negative && !rsp_payload.zero)))
      else $error("flag fields inconsistent");

   // a response appearing after an empty output traces back to an earlier request handshake
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("response without matching request");

endmodule

bind cpu16_register_transfer_unit rtu_checker u_rtu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
